>>> sv/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while reset is released.
`define SC2KM_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("sc2km assertion failed");

// Checked at every edge, reset included.
`define SC2KM_ASSERT_RST(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("sc2km reset assertion failed");

`endif

>>> sv/sc2km_pkg.sv
`default_nettype none

package sc2km_pkg;

    localparam int ROW_COUNT_DEF = 16;
    localparam int MAP_DEPTH_DEF = 256;
    localparam int QUEUE_DEPTH   = 2;

    localparam logic [7:0] CODE_RELEASE  = 8'hF0;
    localparam logic [7:0] CODE_EXTENDED = 8'hE0;
    localparam logic [7:0] EXT_BIT       = 8'h80;
    localparam logic [7:0] ROW_MASK      = 8'h0F;
    localparam logic [7:0] COL_MASK      = 8'h70;
    localparam logic [7:0] UNMAPPED      = 8'hFF;
    localparam logic [7:0] ROW_ALL_UP    = 8'hFF;

    typedef enum logic [1:0] {
        KIND_SCAN   = 2'd0,
        KIND_QUERY  = 2'd1,
        KIND_MAP_WR = 2'd2
    } t_kind;

    // Command from front to back.
    typedef struct packed {
        logic       is_query;
        logic [3:0] row;
        logic [2:0] col;
        logic       level;
    } t_cmd;

    function automatic logic [3:0] entry_row(input logic [7:0] e);
        entry_row = 4'(e & ROW_MASK);
    endfunction

    function automatic logic [2:0] entry_col(input logic [7:0] e);
        entry_col = 3'((e & COL_MASK) >> 4);
    endfunction

endpackage

`default_nettype wire

>>> sv/sc2km_ram.sv
`default_nettype none

module sc2km_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = sc2km_pkg::MAP_DEPTH_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> sv/sc2km_front.sv
`default_nettype none

module sc2km_front #(
    parameter int MAP_DEPTH = sc2km_pkg::MAP_DEPTH_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire logic [1:0]       i_kind,
    input  wire logic [7:0]       i_code,
    input  wire logic [3:0]       i_row_sel,
    input  wire logic [7:0]       i_map_entry,
    output logic                  o_push_valid,
    output sc2km_pkg::t_cmd       o_push_cmd,
    input  wire logic             i_push_ready
);

    localparam int AddrW = $clog2(MAP_DEPTH);

    logic [MAP_DEPTH-1:0] r_map_vld;
    logic                 r_ext, n_ext;
    logic [7:0]           r_prev, n_prev;
    logic                 r_s1_vld, n_s1_vld;
    logic                 r_s1_query, n_s1_query;
    logic                 r_s1_rel, n_s1_rel;
    logic [3:0]           r_s1_row, n_s1_row;
    logic                 r_rd_mapped;

    logic       accept;
    logic       is_prefix;
    logic       key_rd;
    logic       map_wr;
    logic       s1_skip;
    logic [7:0] code_x;
    logic [7:0] ram_q;
    logic [7:0] entry;

    assign is_prefix = (i_code == sc2km_pkg::CODE_RELEASE) ||
                       (i_code == sc2km_pkg::CODE_EXTENDED);
    assign code_x    = r_ext ? (i_code | sc2km_pkg::EXT_BIT) : i_code;
    assign accept    = i_valid && o_ready;
    assign key_rd    = accept && (i_kind == sc2km_pkg::KIND_SCAN) && !is_prefix;
    assign map_wr    = accept && (i_kind == sc2km_pkg::KIND_MAP_WR);

    sc2km_ram #(
        .WIDTH (8),
        .DEPTH (MAP_DEPTH)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (map_wr),
        .i_waddr (i_code[AddrW-1:0]),
        .i_wdata (i_map_entry),
        .i_re    (key_rd),
        .i_raddr (code_x[AddrW-1:0]),
        .o_rdata (ram_q)
    );

    // Prefix tracking
    always_comb begin
        n_ext  = r_ext;
        n_prev = r_prev;
        if (accept && (i_kind == sc2km_pkg::KIND_SCAN)) begin
            if (!is_prefix) begin
                n_ext  = 1'b0;
                n_prev = code_x;
            end else begin
                if (i_code == sc2km_pkg::CODE_EXTENDED) begin
                    n_ext = 1'b1;
                end
                n_prev = i_code;
            end
        end
    end

    // Lookup stage, aligned with the map read data
    always_comb begin
        n_s1_vld   = r_s1_vld;
        n_s1_query = r_s1_query;
        n_s1_rel   = r_s1_rel;
        n_s1_row   = r_s1_row;
        if (o_ready) begin
            n_s1_vld   = key_rd || (accept && (i_kind == sc2km_pkg::KIND_QUERY));
            n_s1_query = (i_kind == sc2km_pkg::KIND_QUERY);
            n_s1_rel   = (r_prev == sc2km_pkg::CODE_RELEASE);
            n_s1_row   = i_row_sel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ext     <= 1'b0;
            r_prev    <= '0;
            r_s1_vld  <= 1'b0;
            r_map_vld <= '0;
        end else begin
            r_ext    <= n_ext;
            r_prev   <= n_prev;
            r_s1_vld <= n_s1_vld;
            if (map_wr) begin
                r_map_vld[i_code[AddrW-1:0]] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_query <= n_s1_query;
        r_s1_rel   <= n_s1_rel;
        r_s1_row   <= n_s1_row;
        if (key_rd) begin
            r_rd_mapped <= r_map_vld[code_x[AddrW-1:0]];
        end
    end

    assign entry   = r_rd_mapped ? ram_q : sc2km_pkg::UNMAPPED;
    // unmapped press: dropped here
    assign s1_skip = !r_s1_query && !r_s1_rel && (entry == sc2km_pkg::UNMAPPED);

    assign o_ready      = !r_s1_vld || s1_skip || i_push_ready;
    assign o_push_valid = r_s1_vld && !s1_skip;

    always_comb begin
        o_push_cmd.is_query = r_s1_query;
        o_push_cmd.row      = r_s1_query ? r_s1_row : sc2km_pkg::entry_row(entry);
        o_push_cmd.col      = sc2km_pkg::entry_col(entry);
        o_push_cmd.level    = r_s1_rel;
    end

endmodule

`default_nettype wire

>>> sv/sc2km_queue.sv
`default_nettype none

module sc2km_queue (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push_valid,
    input  wire sc2km_pkg::t_cmd  i_push_cmd,
    output logic                  o_push_ready,
    output logic                  o_pop_valid,
    output sc2km_pkg::t_cmd       o_pop_cmd,
    input  wire logic             i_pop_ready
);

    localparam int Depth = sc2km_pkg::QUEUE_DEPTH;
    localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW  = $clog2(Depth + 1);

    sc2km_pkg::t_cmd r_mem [Depth];
    logic [PtrW-1:0] r_wp, n_wp;
    logic [PtrW-1:0] r_rp, n_rp;
    logic [CntW-1:0] r_cnt, n_cnt;
    logic            push;
    logic            pop;

    assign o_push_ready = (r_cnt != CntW'(Depth));
    assign o_pop_valid  = (r_cnt != '0);
    assign o_pop_cmd    = r_mem[r_rp];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (push) begin
            n_wp = (r_wp == PtrW'(Depth - 1)) ? '0 : r_wp + 1'b1;
        end
        if (pop) begin
            n_rp = (r_rp == PtrW'(Depth - 1)) ? '0 : r_rp + 1'b1;
        end
        if (push && !pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (pop && !push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_push_cmd;
        end
    end

endmodule

`default_nettype wire

>>> sv/sc2km_back.sv
`default_nettype none

module sc2km_back #(
    parameter int ROW_COUNT = sc2km_pkg::ROW_COUNT_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_pop_valid,
    input  wire sc2km_pkg::t_cmd  i_pop_cmd,
    output logic                  o_pop_ready,
    output logic                  o_valid,
    output logic [7:0]            o_row_bits,
    input  wire logic             i_ready
);

    logic [7:0] r_rows [ROW_COUNT];
    logic       r_out_vld;
    logic [7:0] r_out_bits;
    logic       fire;
    logic [7:0] sel_bits;

    assign o_pop_ready = !i_pop_cmd.is_query || !r_out_vld || i_ready;
    assign fire        = i_pop_valid && o_pop_ready;

    // rows beyond the matrix read as all up
    always_comb begin
        sel_bits = sc2km_pkg::ROW_ALL_UP;
        for (int r = 0; r < ROW_COUNT; r++) begin
            if (i_pop_cmd.row == 4'(r)) begin
                sel_bits = r_rows[r];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < ROW_COUNT; r++) begin
                r_rows[r] <= sc2km_pkg::ROW_ALL_UP;
            end
            r_out_vld <= 1'b0;
        end else begin
            for (int r = 0; r < ROW_COUNT; r++) begin
                if (fire && !i_pop_cmd.is_query && (i_pop_cmd.row == 4'(r))) begin
                    r_rows[r][i_pop_cmd.col] <= i_pop_cmd.level;
                end
            end
            if (fire && i_pop_cmd.is_query) begin
                r_out_vld <= 1'b1;
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && i_pop_cmd.is_query) begin
            r_out_bits <= sel_bits;
        end
    end

    assign o_valid    = r_out_vld;
    assign o_row_bits = r_out_bits;

endmodule

`default_nettype wire

>>> sv/scancode_to_key_matrix_unit.sv
// Throughput: one transaction per cycle of any kind while o_ready is high.
// Path: a row query result passes the lookup stage, the command queue and the output
// register in that order, and is delayed further while the output stalls.
// Scancode and map-write transactions give no result.
// Reset: synchronous, active low; clears prefix state, map valid bits (whole map
// reads unmapped) and sets the key matrix to all ones; no clearing pass.
`default_nettype none

module scancode_to_key_matrix_unit #(
    parameter int ROW_COUNT = sc2km_pkg::ROW_COUNT_DEF,
    parameter int MAP_DEPTH = sc2km_pkg::MAP_DEPTH_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [1:0] i_kind,
    input  wire logic [7:0] i_code,
    input  wire logic [3:0] i_row_sel,
    input  wire logic [7:0] i_map_entry,
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic [7:0]      o_row_bits
);

    logic            push_valid;
    logic            push_ready;
    sc2km_pkg::t_cmd push_cmd;
    logic            pop_valid;
    logic            pop_ready;
    sc2km_pkg::t_cmd pop_cmd;

    sc2km_front #(
        .MAP_DEPTH (MAP_DEPTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_kind       (i_kind),
        .i_code       (i_code),
        .i_row_sel    (i_row_sel),
        .i_map_entry  (i_map_entry),
        .o_push_valid (push_valid),
        .o_push_cmd   (push_cmd),
        .i_push_ready (push_ready)
    );

    sc2km_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .i_push_cmd   (push_cmd),
        .o_push_ready (push_ready),
        .o_pop_valid  (pop_valid),
        .o_pop_cmd    (pop_cmd),
        .i_pop_ready  (pop_ready)
    );

    sc2km_back #(
        .ROW_COUNT (ROW_COUNT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (pop_valid),
        .i_pop_cmd   (pop_cmd),
        .o_pop_ready (pop_ready),
        .o_valid     (o_valid),
        .o_row_bits  (o_row_bits),
        .i_ready     (i_ready)
    );

endmodule

`default_nettype wire

>>> sv/sc2km_checker.sv
`default_nettype none
`include "assert_macros.svh"

module sc2km_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_valid,
    input wire logic       o_ready,
    input wire logic [1:0] i_kind,
    input wire logic       o_valid,
    input wire logic       i_ready
);

    // lookup stage + queue + output register
    localparam int PendMax = sc2km_pkg::QUEUE_DEPTH + 2;
    localparam int PendW   = $clog2(PendMax + 1);

    logic [PendW-1:0] r_pend, n_pend;
    logic             q_acc;
    logic             o_acc;

    assign q_acc = i_valid && o_ready && (i_kind == sc2km_pkg::KIND_QUERY);
    assign o_acc = o_valid && i_ready;

    always_comb begin
        n_pend = r_pend;
        if (q_acc && !o_acc) begin
            n_pend = r_pend + 1'b1;
        end else if (o_acc && !q_acc) begin
            n_pend = r_pend - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            r_pend <= n_pend;
        end
    end

    `SC2KM_ASSERT_RST(a_reset_idle, i_clk, !i_rst_n |=> !o_valid && o_ready)
    `SC2KM_ASSERT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready |=> o_valid)
    `SC2KM_ASSERT(a_result_has_query, i_clk, i_rst_n, o_valid |-> r_pend != '0)
    `SC2KM_ASSERT(a_pend_bound, i_clk, i_rst_n, r_pend <= PendW'(PendMax))

endmodule

bind scancode_to_key_matrix_unit sc2km_checker u_sc2km_checker (.*);

`default_nettype wire
